[hw/rtl/lcdte_pkg.sv]
package lcdte_pkg;

    // result kinds
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_BEEP = 2'd2;

    // control characters
    localparam logic [7:0] CH_BELL = 8'd7;
    localparam logic [7:0] CH_BS   = 8'd8;
    localparam logic [7:0] CH_TAB  = 8'd9;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_VT   = 8'd11;
    localparam logic [7:0] CH_FF   = 8'd12;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_SO   = 8'd14;
    localparam logic [7:0] CH_SI   = 8'd15;

    localparam logic [7:0] GLYPH_SO = 8'h00;
    localparam logic [7:0] GLYPH_SI = 8'h07;

    // controller bytes
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] ROW1_BIT     = 8'h40;
    localparam logic [7:0] COL_MASK     = 8'h3f;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] SPACE        = 8'h20;
    localparam logic [7:0] BEEP_VALUE   = 8'h00;

    // configuration register indexes
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_DSCROLL = 2'd2;

    localparam logic [4:0] COLUMNS_RST = 5'd16;
    localparam logic [1:0] ROWS_RST    = 2'd2;

    // beats kept per character; later ones are dropped
    localparam logic [5:0] RESULT_LIMIT = 6'd43;

endpackage

[hw/rtl/char_lcd_terminal_engine_core.sv]
// Each character passes through start (pending wrap), dispatch and done; a printable or tab
// also goes through check, and a newline, vertical tab or wrap through move. Tab emits one space per
// column up to its stop. A scroll rewrites the screen: each copied cell is read from the screen store
// before its write, then the last row is blanked. Stalls on m_ready hold the engine.
// One character at a time; the next is taken once the engine is back in idle after its last beat.
// Reset (aresetn, synchronous, active low): cursor home, screen of spaces, 16x2, delayed scroll.
module char_lcd_terminal_engine_core #(
    parameter int MAX_COLS = 16,
    parameter int MAX_ROWS = 2,
    parameter int TAB_STOP = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_value,
    output logic       m_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data
);
    import lcdte_pkg::*;

    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_DISPATCH, ST_TAB, ST_CHECK, ST_MOVE,
        ST_SC_ADDR, ST_SC_READ, ST_SC_COPY, ST_SC_BLANK, ST_SC_FIN, ST_DONE
    } state_t;

    function automatic logic [7:0] addr_cmd(input logic [1:0] r, input logic [4:0] c,
                                            input logic [4:0] ec);
        logic [7:0] off;
        logic [7:0] pos;
        off = r[1] ? {3'b000, ec} : 8'h00;
        pos = ({3'b000, c} & COL_MASK) + off;
        return CMD_SET_ADDR | (r[0] ? ROW1_BIT : 8'h00) | pos;
    endfunction

    function automatic logic [AW-1:0] cell_idx(input logic [1:0] r, input logic [4:0] c,
                                               input logic [4:0] ec);
        logic [7:0] p;
        p = 8'(r) * 8'(ec) + 8'(c);
        return p[AW-1:0];
    endfunction

    state_t     state_reg, state_next;
    logic       ret_disp_reg, ret_disp_next;
    logic [7:0] ch_reg, ch_next;
    logic [4:0] col_reg, col_next;
    logic [1:0] row_reg, row_next;
    logic       scrolled_reg, scrolled_next;
    logic [1:0] sy_reg, sy_next;
    logic [4:0] sx_reg, sx_next;
    logic [4:0] stop_reg, stop_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       st_valid_reg, st_valid_next;
    logic [1:0] st_kind_reg, st_kind_next;
    logic [7:0] st_value_reg, st_value_next;
    logic       m_valid_reg, m_valid_next;
    logic [1:0] m_kind_reg, m_kind_next;
    logic [7:0] m_value_reg, m_value_next;
    logic       m_last_reg, m_last_next;
    logic [4:0] columns_reg, columns_next;
    logic [1:0] rows_reg, rows_next;
    logic       dscroll_reg, dscroll_next;

    // screen store with per-entry valid bits; an invalid entry reads as a space
    logic [7:0]    mem [STORE_DEPTH];
    logic          vld_reg [STORE_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          rd_vld_reg;
    logic          mem_we, mem_re, clear_all;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    logic       emit_req, emit_ok, cnt_full, out_free;
    logic [1:0] emit_kind;
    logic [7:0] emit_value;

    logic [4:0] eff_cols;
    logic [1:0] eff_rows;
    logic [2:0] eff_rows3;
    logic [1:0] row_sat, bs_row;
    logic [4:0] col_sat, bs_col, tab_stop;
    logic [5:0] tab_raw;
    logic [7:0] glyph, copy_val;
    logic       defer;
    logic [2:0] row_inc, row_sat_inc;

    logic [5:0] tab_tbl [32];
    for (genvar i = 0; i < 32; i++) begin : g_tab
        assign tab_tbl[i] = 6'((i / TAB_STOP + 1) * TAB_STOP);
    end

    assign eff_cols = (columns_reg == 5'd0) ? 5'd1 :
                      ((columns_reg > 5'(MAX_COLS)) ? 5'(MAX_COLS) : columns_reg);
    assign eff_rows = (rows_reg == 2'd0) ? 2'd1 :
                      (({1'b0, rows_reg} > 3'(MAX_ROWS)) ? 2'(MAX_ROWS) : rows_reg);
    assign eff_rows3 = {1'b0, eff_rows};

    assign row_sat     = (row_reg >= eff_rows) ? eff_rows - 2'd1 : row_reg;
    assign col_sat     = (col_reg > eff_cols) ? eff_cols : col_reg;
    assign row_inc     = {1'b0, row_reg} + 3'd1;
    assign row_sat_inc = {1'b0, row_sat} + 3'd1;

    always_comb begin
        bs_col = col_reg;
        bs_row = row_reg;
        if (col_reg != 5'd0) begin
            bs_col = col_reg - 5'd1;
        end else if (row_reg != 2'd0) begin
            bs_row = row_reg - 2'd1;
            bs_col = eff_cols - 5'd1;
        end
    end

    assign tab_raw  = tab_tbl[col_reg];
    assign tab_stop = (tab_raw > {1'b0, eff_cols}) ? eff_cols : tab_raw[4:0];
    assign glyph    = (ch_reg == CH_SO) ? GLYPH_SO : ((ch_reg == CH_SI) ? GLYPH_SI : ch_reg);
    assign copy_val = rd_vld_reg ? rd_data_reg : SPACE;
    assign defer    = dscroll_reg | scrolled_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign cnt_full = (cnt_reg >= RESULT_LIMIT);
    assign emit_ok  = cnt_full || !st_valid_reg || out_free;

    always_comb begin
        state_next    = state_reg;
        ret_disp_next = ret_disp_reg;
        ch_next       = ch_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        scrolled_next = scrolled_reg;
        sy_next       = sy_reg;
        sx_next       = sx_reg;
        stop_next     = stop_reg;
        cnt_next      = cnt_reg;
        st_valid_next = st_valid_reg;
        st_kind_next  = st_kind_reg;
        st_value_next = st_value_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;
        columns_next  = columns_reg;
        rows_next     = rows_reg;
        dscroll_next  = dscroll_reg;
        emit_req      = 1'b0;
        emit_kind     = KIND_CMD;
        emit_value    = 8'h00;
        mem_we        = 1'b0;
        mem_waddr     = cell_idx(row_reg, col_reg, eff_cols);
        mem_wdata     = SPACE;
        mem_re        = 1'b0;
        mem_raddr     = cell_idx(sy_reg + 2'd1, sx_reg, eff_cols);
        clear_all     = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_COLUMNS: columns_next = cfg_data;
                CFG_ROWS:    rows_next    = cfg_data[1:0];
                CFG_DSCROLL: dscroll_next = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ch_next       = s_ch;
                    cnt_next      = 6'd0;
                    scrolled_next = 1'b0;
                    state_next    = ST_START;
                end
            end
            ST_START: begin
                col_next   = col_sat;
                row_next   = row_sat;
                state_next = ST_DISPATCH;
                // pending wrap
                if (col_sat >= eff_cols && !(ch_reg inside {CH_BELL, CH_BS, CH_FF})) begin
                    col_next = 5'd0;
                    if (row_sat_inc >= eff_rows3) begin
                        row_next      = eff_rows - 2'd1;
                        scrolled_next = 1'b1;
                        sy_next       = 2'd0;
                        sx_next       = 5'd0;
                        ret_disp_next = 1'b1;
                        state_next    = ST_SC_ADDR;
                    end else begin
                        row_next = row_sat_inc[1:0];
                    end
                end
            end
            ST_DISPATCH: begin
                case (ch_reg)
                    CH_BELL: begin
                        emit_req   = 1'b1;
                        emit_kind  = KIND_BEEP;
                        emit_value = BEEP_VALUE;
                        if (emit_ok) state_next = ST_DONE;
                    end
                    CH_BS: begin
                        emit_req   = 1'b1;
                        emit_value = addr_cmd(bs_row, bs_col, eff_cols);
                        if (emit_ok) begin
                            col_next   = bs_col;
                            row_next   = bs_row;
                            state_next = ST_DONE;
                        end
                    end
                    CH_FF: begin
                        emit_req   = 1'b1;
                        emit_value = CMD_CLEAR;
                        if (emit_ok) begin
                            clear_all  = 1'b1;
                            col_next   = 5'd0;
                            row_next   = 2'd0;
                            state_next = ST_DONE;
                        end
                    end
                    CH_LF: begin
                        col_next   = 5'd0;
                        row_next   = row_inc[1:0];
                        state_next = ST_MOVE;
                    end
                    CH_VT: begin
                        row_next   = row_inc[1:0];
                        state_next = ST_MOVE;
                    end
                    CH_CR: begin
                        emit_req   = 1'b1;
                        emit_value = addr_cmd(row_reg, 5'd0, eff_cols);
                        if (emit_ok) begin
                            col_next   = 5'd0;
                            state_next = ST_DONE;
                        end
                    end
                    CH_TAB: begin
                        stop_next  = tab_stop;
                        state_next = ST_TAB;
                    end
                    default: begin
                        emit_req   = 1'b1;
                        emit_kind  = KIND_DATA;
                        emit_value = glyph;
                        if (emit_ok) begin
                            mem_we     = 1'b1;
                            mem_wdata  = glyph;
                            col_next   = col_reg + 5'd1;
                            state_next = ST_CHECK;
                        end
                    end
                endcase
            end
            ST_TAB: begin
                emit_req   = 1'b1;
                emit_kind  = KIND_DATA;
                emit_value = SPACE;
                if (emit_ok) begin
                    mem_we   = 1'b1;
                    col_next = col_reg + 5'd1;
                    if (col_reg + 5'd1 >= stop_reg) state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = ST_DONE;
                if (col_reg >= eff_cols && (row_inc < eff_rows3 || !defer)) begin
                    col_next   = 5'd0;
                    row_next   = row_inc[1:0];
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE: begin
                if ({1'b0, row_reg} >= eff_rows3) begin
                    row_next      = eff_rows - 2'd1;
                    sy_next       = 2'd0;
                    sx_next       = 5'd0;
                    ret_disp_next = 1'b0;
                    state_next    = ST_SC_ADDR;
                end else begin
                    emit_req   = 1'b1;
                    emit_value = addr_cmd(row_reg, col_reg, eff_cols);
                    if (emit_ok) state_next = ST_DONE;
                end
            end
            ST_SC_ADDR: begin
                emit_req   = 1'b1;
                emit_value = addr_cmd(sy_reg, 5'd0, eff_cols);
                if (emit_ok) begin
                    state_next = ({1'b0, sy_reg} + 3'd1 < eff_rows3) ? ST_SC_READ : ST_SC_BLANK;
                end
            end
            ST_SC_READ: begin
                mem_re     = 1'b1;
                state_next = ST_SC_COPY;
            end
            ST_SC_COPY: begin
                emit_req   = 1'b1;
                emit_kind  = KIND_DATA;
                emit_value = copy_val;
                if (emit_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = cell_idx(sy_reg, sx_reg, eff_cols);
                    mem_wdata = copy_val;
                    if (sx_reg + 5'd1 >= eff_cols) begin
                        sx_next    = 5'd0;
                        sy_next    = sy_reg + 2'd1;
                        state_next = ST_SC_ADDR;
                    end else begin
                        sx_next    = sx_reg + 5'd1;
                        state_next = ST_SC_READ;
                    end
                end
            end
            ST_SC_BLANK: begin
                emit_req   = 1'b1;
                emit_kind  = KIND_DATA;
                emit_value = SPACE;
                if (emit_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = cell_idx(sy_reg, sx_reg, eff_cols);
                    if (sx_reg + 5'd1 >= eff_cols) begin
                        sx_next    = 5'd0;
                        state_next = ST_SC_FIN;
                    end else begin
                        sx_next = sx_reg + 5'd1;
                    end
                end
            end
            ST_SC_FIN: begin
                emit_req   = 1'b1;
                emit_value = addr_cmd(row_reg, col_reg, eff_cols);
                if (emit_ok) state_next = ret_disp_reg ? ST_DISPATCH : ST_DONE;
            end
            ST_DONE: begin
                // flush the held beat with last set
                if (!st_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = st_kind_reg;
                    m_value_next  = st_value_reg;
                    m_last_next   = 1'b1;
                    st_valid_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // one beat is held back so that last can be set on the final one
        if (emit_req && emit_ok && !cnt_full) begin
            if (st_valid_reg) begin
                m_valid_next = 1'b1;
                m_kind_next  = st_kind_reg;
                m_value_next = st_value_reg;
                m_last_next  = 1'b0;
            end
            st_valid_next = 1'b1;
            st_kind_next  = emit_kind;
            st_value_next = emit_value;
            cnt_next      = cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            col_reg      <= 5'd0;
            row_reg      <= 2'd0;
            cnt_reg      <= 6'd0;
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            columns_reg  <= COLUMNS_RST;
            rows_reg     <= ROWS_RST;
            dscroll_reg  <= 1'b1;
        end else begin
            state_reg     <= state_next;
            ret_disp_reg  <= ret_disp_next;
            ch_reg        <= ch_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            scrolled_reg  <= scrolled_next;
            sy_reg        <= sy_next;
            sx_reg        <= sx_next;
            stop_reg      <= stop_next;
            cnt_reg       <= cnt_next;
            st_valid_reg  <= st_valid_next;
            st_kind_reg   <= st_kind_next;
            st_value_reg  <= st_value_next;
            m_valid_reg   <= m_valid_next;
            m_kind_reg    <= m_kind_next;
            m_value_reg   <= m_value_next;
            m_last_reg    <= m_last_next;
            columns_reg   <= columns_next;
            rows_reg      <= rows_next;
            dscroll_reg   <= dscroll_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
            rd_vld_reg  <= vld_reg[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear_all) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (mem_we) begin
            vld_reg[mem_waddr] <= 1'b1;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_value   = m_value_reg;
    assign m_last    = m_last_reg;

    ap_idle_no_held_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !st_valid_reg)
        else $error("held beat left over when idle");

    ap_cnt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= RESULT_LIMIT)
        else $error("beat count past limit");

    ap_write_with_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> emit_req)
        else $error("store write without a bus write");

    ap_read_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |-> (int'(mem_raddr) < STORE_DEPTH))
        else $error("scroll read outside the store");

    ap_idle_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (int'(row_reg) < MAX_ROWS && int'(col_reg) <= MAX_COLS))
        else $error("cursor outside the screen when idle");

endmodule

[dv/char_lcd_terminal_engine_core_test.sv]
module char_lcd_terminal_engine_core_test;
    import lcdte_pkg::*;

    localparam int MAX_COLS     = 16;
    localparam int MAX_ROWS     = 2;
    localparam int TAB_STOP     = 8;
    localparam int SHADOW_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 64;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } bus_write_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_ch = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_value;
    logic       m_last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = 2'd0;
    logic [4:0] cfg_data = 5'd0;

    char_lcd_terminal_engine_core #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS),
        .TAB_STOP(TAB_STOP)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_ch(s_ch),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_value(m_value),
        .m_last(m_last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // predicted display state
    logic [7:0]  shadow [SHADOW_DEPTH];
    int unsigned cur_col, cur_row, eff_cols, eff_rows;
    logic [4:0]  cols_reg;
    logic [1:0]  rows_reg;
    logic        dscroll_reg;

    bus_write_t writes_due[$];
    bus_write_t char_writes[$];

    int  bad_beats = 0;
    int  cycles = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  hold_left = 0;
    int  stall_left = 0;

    function automatic void reset_display();
        foreach (shadow[i]) shadow[i] = SPACE;
        cur_col = 0;
        cur_row = 0;
        cols_reg = COLUMNS_RST;
        rows_reg = ROWS_RST;
        dscroll_reg = 1'b1;
    endfunction

    function automatic void add_write(logic [1:0] k, logic [7:0] v);
        if (char_writes.size() < int'(RESULT_LIMIT))
            char_writes.push_back('{kind: k, value: v, last: 1'b0});
    endfunction

    function automatic logic [7:0] addr_byte(int unsigned row, int unsigned col);
        int unsigned off;
        off = ((row & 2) != 0) ? eff_cols : 0;
        return 8'(CMD_SET_ADDR | (((row & 1) != 0) ? ROW1_BIT : 8'h00)
                  | ((col & COL_MASK) + off));
    endfunction

    function automatic void store_cell(int unsigned row, int unsigned col, logic [7:0] v);
        int unsigned idx;
        idx = row * eff_cols + col;
        if (idx < SHADOW_DEPTH) shadow[idx] = v;
    endfunction

    function automatic void scroll_shadow();
        int unsigned y, x, src;
        logic [7:0]  v;
        for (y = 0; y + 1 < eff_rows; y++) begin
            add_write(KIND_CMD, addr_byte(y, 0));
            for (x = 0; x < eff_cols; x++) begin
                src = (y + 1) * eff_cols + x;
                v = (src < SHADOW_DEPTH) ? shadow[src] : SPACE;
                store_cell(y, x, v);
                add_write(KIND_DATA, v);
            end
        end
        add_write(KIND_CMD, addr_byte(eff_rows - 1, 0));
        for (x = 0; x < eff_cols; x++) begin
            store_cell(eff_rows - 1, x, SPACE);
            add_write(KIND_DATA, SPACE);
        end
        add_write(KIND_CMD, addr_byte(cur_row, cur_col));
    endfunction

    // bus writes caused by one character; updates the predicted display
    function automatic void compute_bus_writes(logic [7:0] c);
        bit          scrolled, defer, move;
        int unsigned stop, x;
        logic [7:0]  g;
        bus_write_t  w;
        scrolled = 1'b0;
        move = 1'b0;
        char_writes.delete();
        eff_cols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
        eff_rows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
        if (cur_row >= eff_rows) cur_row = eff_rows - 1;
        if (cur_col > eff_cols) cur_col = eff_cols;

        // wrap left pending by the previous character
        if (cur_col >= eff_cols && c != CH_BELL && c != CH_BS && c != CH_FF) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= eff_rows) begin
                cur_row = eff_rows - 1;
                scroll_shadow();
                scrolled = 1'b1;
            end
        end
        defer = dscroll_reg || scrolled;

        case (c)
            CH_BELL: add_write(KIND_BEEP, BEEP_VALUE);
            CH_BS: begin
                if (cur_col > 0) begin
                    cur_col--;
                end else if (cur_row > 0) begin
                    cur_row--;
                    cur_col = eff_cols - 1;
                end
                add_write(KIND_CMD, addr_byte(cur_row, cur_col));
            end
            CH_FF: begin
                foreach (shadow[i]) shadow[i] = SPACE;
                cur_col = 0;
                cur_row = 0;
                add_write(KIND_CMD, CMD_CLEAR);
            end
            CH_LF: begin
                cur_col = 0;
                cur_row++;
                move = 1'b1;
            end
            CH_VT: begin
                cur_row++;
                move = 1'b1;
            end
            CH_CR: begin
                cur_col = 0;
                add_write(KIND_CMD, addr_byte(cur_row, 0));
            end
            CH_TAB: begin
                stop = (cur_col / TAB_STOP + 1) * TAB_STOP;
                if (stop > eff_cols) stop = eff_cols;
                for (x = cur_col; x < stop; x++) begin
                    store_cell(cur_row, x, SPACE);
                    add_write(KIND_DATA, SPACE);
                end
                if (stop > cur_col) cur_col = stop;
                if (cur_col >= eff_cols && (cur_row + 1 < eff_rows || !defer)) begin
                    cur_col = 0;
                    cur_row++;
                    move = 1'b1;
                end
            end
            default: begin
                g = (c == CH_SO) ? GLYPH_SO : ((c == CH_SI) ? GLYPH_SI : c);
                store_cell(cur_row, cur_col, g);
                add_write(KIND_DATA, g);
                cur_col++;
                if (cur_col >= eff_cols && (cur_row + 1 < eff_rows || !defer)) begin
                    cur_col = 0;
                    cur_row++;
                    move = 1'b1;
                end
            end
        endcase

        if (move) begin
            if (cur_row >= eff_rows) begin
                cur_row = eff_rows - 1;
                scroll_shadow();
            end else begin
                add_write(KIND_CMD, addr_byte(cur_row, cur_col));
            end
        end

        if (char_writes.size() > 0) begin
            w = char_writes.pop_back();
            w.last = 1'b1;
            char_writes.push_back(w);
        end
        foreach (char_writes[i]) writes_due.push_back(char_writes[i]);
    endfunction

    // result checker
    always @(posedge aclk) begin
        bus_write_t w;
        if (aresetn && m_valid && m_ready) begin
            if (writes_due.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("unexpected beat: kind=%0d value=%02h last=%0b",
                             m_kind, m_value, m_last);
            end else begin
                w = writes_due.pop_front();
                if (w.kind !== m_kind || w.value !== m_value || w.last !== m_last) begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("mismatch: expected kind=%0d value=%02h last=%0b,",
                                 w.kind, w.value, w.last,
                                 " got kind=%0d value=%02h last=%0b",
                                 m_kind, m_value, m_last);
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int tx_gap();
        int r;
        if (!tx_idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 8'($urandom_range(8'h20, 8'h7e));
        if (r < 85) return 8'($urandom_range(CH_BELL, CH_SI));
        return 8'($urandom_range(0, 255));
    endfunction

    // valid stays up after a beat; the next send or release decides at the falling edge
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = tx_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_ch <= c;
        do @(posedge aclk); while (!s_ready);
        compute_bus_writes(c);
    endtask

    task automatic send_string(input string text);
        for (int i = 0; i < text.len(); i++) send_char(text[i]);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (writes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_COLUMNS: cols_reg = data;
            CFG_ROWS:    rows_reg = data[1:0];
            CFG_DSCROLL: dscroll_reg = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [4:0] cols, input logic [4:0] rows_data,
                             input logic [4:0] ds_data);
        settle();
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rows_data);
        write_reg(CFG_DSCROLL, ds_data);
    endtask

    // reset geometry: glyph remaps, byte extremes and every control code
    task automatic test_controls();
        send_char(8'h48);
        send_char(CH_SO);
        send_char(CH_SI);
        send_char(8'h00);
        send_char(8'hff);
        send_char(CH_TAB);
        send_char(CH_BELL);
        send_char(CH_BS);
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(CH_VT);   // already on bottom line: scrolls
        send_char(CH_FF);
        send_char(CH_BS);   // top left: cursor stays
    endtask

    // narrow screen: wrap, pending wrap held by bell, tab after a scroll
    task automatic test_wrap_and_scroll();
        configure(5'd3, 5'd2, 5'd1);
        send_char(CH_FF);
        send_string("abcdef");
        send_char(CH_BELL);
        send_char(CH_TAB);
        send_char(8'h67);
    endtask

    // resize without clearing, double scroll guard, out-of-range registers
    task automatic test_geometry();
        configure(5'd16, 5'd2, 5'd0);
        send_char(CH_LF);
        send_string("AB");
        configure(5'd1, 5'd2, 5'd0);
        send_string("XY");
        configure(5'd0, 5'd0, 5'd1);
        send_char(8'h71);
        send_char(CH_LF);
        configure(5'd31, 5'd3, 5'd30);
        settle();
        write_reg(CFG_UNUSED, 5'd31);
        send_char(8'h72);
        send_char(CH_TAB);
    endtask

    task automatic test_random_traffic();
        logic [4:0] cols;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0) cols = 5'd16;
            else if (phase == 1) cols = 5'd1;
            else if ($urandom_range(0, 99) < 80) cols = 5'($urandom_range(1, 16));
            else cols = 5'($urandom_range(0, 31));
            configure(cols, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            tx_idle_on = (phase != 2);
            rx_idle_on = (phase != 2);
            if ($urandom_range(0, 99) < 70) send_char(CH_FF);
            repeat (25) send_char(rand_char());
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver holds off while characters keep coming
    task automatic test_backpressure();
        configure(5'd16, 5'd2, 5'd1);
        tx_idle_on = 1'b0;
        send_char(CH_FF);
        hold_left = 300;
        repeat (5) send_char(rand_char());
        send_char(CH_LF);
        send_char(CH_LF);
        repeat (5) send_char(rand_char());
        tx_idle_on = 1'b1;
    endtask

    initial begin
        reset_display();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_controls();
        test_wrap_and_scroll();
        test_geometry();
        test_random_traffic();
        test_backpressure();

        settle();
        if (bad_beats == 0 && writes_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
